// ----- rtl/core/led_driver_serial_frame_tx_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef LED_DRIVER_SERIAL_FRAME_TX_MACROS_SVH
`define LED_DRIVER_SERIAL_FRAME_TX_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lsft_pkg.sv -----
package lsft_pkg;

    // Field and register widths
    localparam int unsigned TICK_W      = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_TDATA_W = 24;

    // Register reset values
    localparam logic [TICK_W-1:0] HALF_RESET  = 16'd20;
    localparam logic [TICK_W-1:0] SETUP_RESET = 16'd10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP = 1'b1;

    // Item kinds
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_BRIGHT = 1'b1;

    // Display control codes
    localparam logic [BYTE_W-1:0] DISP_CTRL_OFF = 8'h80;
    localparam logic [BYTE_W-1:0] DISP_CTRL_ON  = 8'h88;
    localparam logic [BYTE_W-1:0] LEVEL_CLAMP   = 8'd8;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified byte job
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first;
        logic              last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [TICK_W-1:0] half;
        logic [TICK_W-1:0] setup;
    } timing_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BITS,
        PH_ACK,
        PH_STOP
    } phase_t;

    // Map a brightness level onto its display control byte
    function automatic logic [BYTE_W-1:0] bright_code(input logic [BYTE_W-1:0] level);
        logic [BYTE_W-1:0] lvl;
        logic [BYTE_W-1:0] code;
        begin
            lvl = (level > LEVEL_CLAMP) ? LEVEL_CLAMP : level;
            if (level == '0)
            begin
                code = DISP_CTRL_OFF;
            end
            else
            begin
                code = DISP_CTRL_ON | (lvl - 8'd1);
            end
            return code;
        end
    endfunction

endpackage

// ----- rtl/core/lsft_front.sv -----
module lsft_front
    import lsft_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  q_status_t            q_status,
    output logic                 push,
    output job_t                 push_job
);

    logic cmd;

    assign cmd = s_axis_tuser[0];

    // Accept whenever the queue has room
    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && !q_status.full;

    // Classify: a brightness item becomes a full one-byte frame
    always_comb
    begin
        if (cmd == CMD_BRIGHT)
        begin
            push_job.data_byte = bright_code(s_axis_tdata);
            push_job.first     = 1'b1;
            push_job.last      = 1'b1;
        end
        else
        begin
            push_job.data_byte = s_axis_tdata;
            push_job.first     = s_axis_tuser[1];
            push_job.last      = s_axis_tlast;
        end
    end

endmodule

// ----- rtl/core/lsft_queue.sv -----
module lsft_queue
    import lsft_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t status
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/core/lsft_back.sv -----
module lsft_back
    import lsft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  timing_t                timing,
    input  job_t                   head,
    input  q_status_t              q_status,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    phase_t            phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic [2:0]        bit_reg, bit_next;
    job_t              job_reg, job_next;
    logic              clock_level_reg, clock_level_next;
    logic              data_level_reg, data_level_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_clk_reg, out_clk_next;
    logic              out_dat_reg, out_dat_next;
    logic [TICK_W-1:0] out_hold_reg, out_hold_next;
    logic              out_last_reg, out_last_next;

    logic              advance;
    logic              seg_valid;
    logic              seg_clk;
    logic              seg_dat;
    logic [TICK_W-1:0] seg_hold;
    logic              seg_last;
    logic              cur_bit;
    phase_t            aft_phase;
    logic [1:0]        aft_sub;
    logic [2:0]        aft_bit;

    // Output slot is free when empty or being taken
    assign advance = !out_valid_reg || m_axis_tready;
    assign cur_bit = job_reg.data_byte[bit_reg];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - TICK_W - 2){1'b0}}, out_hold_reg,
                            out_dat_reg, out_clk_reg};

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            sub_reg         <= '0;
            bit_reg         <= '0;
            clock_level_reg <= 1'b0;
            data_level_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            sub_reg         <= sub_next;
            bit_reg         <= bit_next;
            clock_level_reg <= clock_level_next;
            data_level_reg  <= data_level_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Job and output payload
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        out_clk_reg  <= out_clk_next;
        out_dat_reg  <= out_dat_next;
        out_hold_reg <= out_hold_next;
        out_last_reg <= out_last_next;
    end

    // Build the current segment and the state after it
    always_comb
    begin
        seg_valid = 1'b1;
        seg_clk   = 1'b0;
        seg_dat   = 1'b0;
        seg_hold  = timing.half;
        seg_last  = 1'b0;
        aft_phase = phase_reg;
        aft_sub   = sub_reg + 2'd1;
        aft_bit   = bit_reg;
        case (phase_reg)
            PH_START:
            begin
                seg_clk = 1'b1;
                seg_dat = (sub_reg == 2'd0);
                if (sub_reg == 2'd1)
                begin
                    aft_phase = PH_BITS;
                    aft_sub   = '0;
                    aft_bit   = '0;
                end
            end
            PH_BITS:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        seg_dat  = data_level_reg;
                        seg_hold = timing.setup;
                    end
                    2'd1:
                    begin
                        seg_dat = cur_bit;
                    end
                    default:
                    begin
                        seg_clk = 1'b1;
                        seg_dat = cur_bit;
                        aft_sub = '0;
                        if (bit_reg == 3'd7)
                        begin
                            aft_phase = PH_ACK;
                        end
                        else
                        begin
                            aft_bit = bit_reg + 3'd1;
                        end
                    end
                endcase
            end
            PH_ACK:
            begin
                seg_dat = 1'b1;
                seg_clk = (sub_reg == 2'd1);
                if (sub_reg == 2'd2)
                begin
                    seg_last  = !job_reg.last;
                    aft_phase = job_reg.last ? PH_STOP : PH_IDLE;
                    aft_sub   = '0;
                end
            end
            PH_STOP:
            begin
                case (sub_reg)
                    2'd0:
                    begin
                        seg_clk = clock_level_reg;
                    end
                    2'd1:
                    begin
                        seg_clk = 1'b1;
                    end
                    default:
                    begin
                        seg_clk   = 1'b1;
                        seg_dat   = 1'b1;
                        seg_last  = 1'b1;
                        aft_phase = PH_IDLE;
                        aft_sub   = '0;
                    end
                endcase
            end
            default:
            begin
                seg_valid = 1'b0;
                aft_sub   = sub_reg;
            end
        endcase
    end

    // Step the sequencer, pop the next job without a gap
    always_comb
    begin
        phase_next       = phase_reg;
        sub_next         = sub_reg;
        bit_next         = bit_reg;
        job_next         = job_reg;
        pop              = 1'b0;
        clock_level_next = clock_level_reg;
        data_level_next  = data_level_reg;
        out_valid_next   = out_valid_reg;
        out_clk_next     = out_clk_reg;
        out_dat_next     = out_dat_reg;
        out_hold_next    = out_hold_reg;
        out_last_next    = out_last_reg;

        if (advance)
        begin
            out_valid_next = seg_valid;
            out_clk_next   = seg_clk;
            out_dat_next   = seg_dat;
            out_hold_next  = seg_hold;
            out_last_next  = seg_last;
        end

        if (advance && seg_valid)
        begin
            clock_level_next = seg_clk;
            data_level_next  = seg_dat;
            phase_next       = aft_phase;
            sub_next         = aft_sub;
            bit_next         = aft_bit;
        end

        if (((phase_reg == PH_IDLE) || (advance && seg_last)) && !q_status.empty)
        begin
            pop        = 1'b1;
            job_next   = head;
            phase_next = head.first ? PH_START : PH_BITS;
            sub_next   = '0;
            bit_next   = '0;
        end
    end

endmodule

// ----- rtl/core/led_driver_serial_frame_tx.sv -----
// Two-wire LSB-first transmitter for an LED display driver.
// Input channel s_axis_*: one item per byte. tdata is the byte (or the
// brightness level), tuser[0] is the command (0 data byte, 1 brightness),
// tuser[1] asks for a start condition, tlast asks for a stop condition.
// Output channel m_axis_*: one item per pin segment: clock level, data
// level and hold ticks in tdata, tlast on the final segment of an input.
// A byte gives 27 segments, plus 2 for start and 3 for stop; a brightness
// item gives 32. The output register delivers one segment per cycle when
// the receiver does not stall, and an accepted item passes through the job
// queue, the job register and the output register before its first segment
// shows. A two-entry job queue lets the input accept up to two items ahead
// of the sequencer. A stalled receiver holds the current segment; the
// sequencer and then the input stop once the queue fills.
// Write half_period_ticks (index 0) and data_setup_ticks (index 1) through
// cfg_we/cfg_addr/cfg_wdata while the block is idle.
// Reset sets the holds to 20 and 10 ticks, records both lines as low and
// empties the queue.
module led_driver_serial_frame_tx
    import lsft_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [TICK_W-1:0]      cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [BYTE_W-1:0]      s_axis_tdata,   // data_byte
    input  logic [IN_USER_W-1:0]   s_axis_tuser,   // cmd, first_of_frame
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // clock_pin, data_pin, hold_ticks[15:0]
    output logic                   m_axis_tlast
);

    logic [TICK_W-1:0] half_reg;
    logic [TICK_W-1:0] setup_reg;
    timing_t           timing;
    q_status_t         q_status;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              head;

    assign timing.half  = half_reg;
    assign timing.setup = setup_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg  <= HALF_RESET;
            setup_reg <= SETUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_HALF:  half_reg  <= cfg_wdata;
                REG_SETUP: setup_reg <= cfg_wdata;
                default:   half_reg  <= half_reg;
            endcase
        end
    end

    lsft_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    lsft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    lsft_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timing        (timing),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/core/lsft_checker.sv -----
`include "led_driver_serial_frame_tx_macros.svh"

module lsft_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled segment must hold its levels, hold time and last mark
    `LSFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output segment changed")

    // Every item ends with the data line released high
    `LSFT_ASSERT_NOW(a_last_data_high, m_axis_tvalid && m_axis_tlast, m_axis_tdata[1], "final segment leaves data line low")

    // Pad bits above hold_ticks stay zero
    `LSFT_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:18] == 6'd0, "output pad bits set")

endmodule

bind led_driver_serial_frame_tx lsft_checker u_lsft_checker (.*);
